>>> rtl/sida_pkg.sv
// shared widths, ascii codes and control types of the decimal printer
`default_nettype none

package sida_pkg;

  localparam int VALUE_W     = 32;
  localparam int TAG_W       = 8;
  localparam int CHAR_W      = 8;
  localparam int NUM_DIGITS  = 10;
  localparam int DIGIT_W     = 4;
  localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int BIT_CNT_W   = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // controller to datapath commands
  typedef struct packed {
    logic                   load;
    logic                   shift;
    logic                   put_minus;
    logic                   put_digit;
    logic                   last;
    logic [DIGIT_IDX_W-1:0] digit_sel;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic                   neg;
    logic [DIGIT_IDX_W-1:0] top_digit;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/sida_datapath.sv
// magnitude, bit-serial binary to bcd shifter and output character register
`default_nettype none

module sida_datapath (
  input  wire                          clk,
  input  sida_pkg::cmd_t               cmd,
  input  wire [sida_pkg::VALUE_W-1:0]  value,
  input  wire [sida_pkg::TAG_W-1:0]    stream_tag,
  output sida_pkg::stat_t              stat,
  output logic [sida_pkg::CHAR_W-1:0]  character,
  output logic [sida_pkg::TAG_W-1:0]   tag_out,
  output logic                         last_char
);
  import sida_pkg::*;

  logic [VALUE_W-1:0]                   bin;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   bcd;
  logic [TAG_W-1:0]                     tag;
  logic                                 neg;

  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   adj;
  logic [BCD_W+VALUE_W-1:0]             shifted;
  logic [DIGIT_IDX_W-1:0]               top;

  // add three to every digit of five or more before each shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd[i] >= DIGIT_W'(5)) ? bcd[i] + DIGIT_W'(3) : bcd[i];
    end
    shifted = {adj, bin} << 1;
  end

  // highest nonzero digit, zero when the whole number is zero
  always_comb begin
    top = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i] != '0) top = DIGIT_IDX_W'(i);
    end
  end

  assign stat.neg       = neg;
  assign stat.top_digit = top;

  // conversion registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[VALUE_W-1];
      bin <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
      bcd <= '0;
      tag <= stream_tag;
    end else if (cmd.shift) begin
      bcd <= shifted[BCD_W+VALUE_W-1:VALUE_W];
      bin <= shifted[VALUE_W-1:0];
    end
  end

  // output character register
  always_ff @(posedge clk) begin
    if (cmd.put_minus) begin
      character <= CHAR_MINUS;
      tag_out   <= tag;
      last_char <= 1'b0;
    end else if (cmd.put_digit) begin
      character <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, bcd[cmd.digit_sel]};
      tag_out   <= tag;
      last_char <= cmd.last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sida_ctrl.sv
// sequencing state machine: load, shift, sign, then digits msd first
`default_nettype none

module sida_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire              out_stall,
  input  sida_pkg::stat_t  stat,
  output sida_pkg::cmd_t   cmd
);
  import sida_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    CONV,
    PREP,
    EMIT
  } state_t;

  state_t                 state;
  logic [BIT_CNT_W-1:0]   cnt;
  logic [DIGIT_IDX_W-1:0] pos;
  logic                   sign_pend;
  logic                   slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != IDLE);

  // commands for this cycle
  always_comb begin
    cmd           = '0;
    cmd.digit_sel = pos;
    cmd.last      = (pos == '0);
    case (state)
      IDLE: cmd.load = in_valid;
      CONV: cmd.shift = 1'b1;
      EMIT: begin
        if (slot_free) begin
          if (sign_pend) cmd.put_minus = 1'b1;
          else           cmd.put_digit = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  // state, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      pos       <= '0;
      sign_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.put_minus || cmd.put_digit) out_valid <= 1'b1;
      else if (!out_stall)                out_valid <= 1'b0;

      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= CONV;
            cnt   <= '0;
          end
        end
        CONV: begin
          cnt <= cnt + BIT_CNT_W'(1);
          if (cnt == BIT_CNT_W'(VALUE_W - 1)) state <= PREP;
        end
        PREP: begin
          pos       <= stat.top_digit;
          sign_pend <= stat.neg;
          state     <= EMIT;
        end
        EMIT: begin
          if (slot_free) begin
            if (sign_pend)        sign_pend <= 1'b0;
            else if (pos == '0)   state <= IDLE;
            else                  pos <= pos - DIGIT_IDX_W'(1);
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/signed_int_to_decimal_ascii.sv
// top level: signed 32-bit integer to decimal ascii, one character per transaction
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  input   | in_valid / in_stall  | value[31:0] signed, stream_tag[7:0]
//  output  | out_valid / out_stall| character[7:0], tag_out[7:0], last_char
//
// a number holds the input through conversion and emission of its n = 1..11
// characters: the bit-serial binary to bcd shifter, a prep state to find the leading
// digit, then one character per cycle into the output register with no output stall.
// output stalls hold the character register and pause emission; the last
// character may still wait while the next number is taken and converted.
// rst is synchronous and clears the controller; no clearing pass is needed.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [sida_pkg::VALUE_W-1:0]  value,
  input  wire [sida_pkg::TAG_W-1:0]    stream_tag,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [sida_pkg::CHAR_W-1:0]  character,
  output logic [sida_pkg::TAG_W-1:0]   tag_out,
  output logic                         last_char
);
  import sida_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  sida_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // conversion and output registers
  sida_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .value      (value),
    .stream_tag (stream_tag),
    .stat       (stat),
    .character  (character),
    .tag_out    (tag_out),
    .last_char  (last_char)
  );

endmodule

`default_nettype wire

>>> rtl/sida_checker.sv
// port-level checks of the decimal printer and their bind to the top level
`default_nettype none

module sida_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_stall,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [sida_pkg::CHAR_W-1:0]   character,
  input wire [sida_pkg::TAG_W-1:0]    tag_out,
  input wire                          last_char
);
  import sida_pkg::*;

  // an accepted number keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after a transaction");

  // inside a number the next character follows at once with the same tag
  a_chars_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_char) |=> (out_valid && tag_out == $past(tag_out)))
    else $error("gap or tag change inside a number");

  // while the input is open only a final character can be pending
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_stall) |-> last_char)
    else $error("unfinished number while input open");

  // a minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && character == CHAR_MINUS) |-> !last_char)
    else $error("number ends in a minus sign");

  // only a minus sign or a digit comes out
  a_char_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == CHAR_MINUS ||
                   (character >= CHAR_ZERO && character <= CHAR_NINE)))
    else $error("character outside minus and digits");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .character (character),
  .tag_out   (tag_out),
  .last_char (last_char)
);

`default_nettype wire

>>> bench/tb_top.sv
// testbench for the decimal ascii printer: directed number table, then random numbers vs predictor
`timescale 1ns / 100ps

module tb_top;

  import sida_pkg::*;

  // receiver stall patterns
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_EVERY_THIRD,
    STALL_HOLD
  } stall_mode_t;

  // one expected output character
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } glyph_t;

  localparam int RANDOM_NUMBERS = 200;
  localparam int DRAIN_LIMIT    = 20000;

  logic                clk;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [VALUE_W-1:0]  value      = '0;
  logic [TAG_W-1:0]    stream_tag = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [CHAR_W-1:0]   character;
  logic [TAG_W-1:0]    tag_out;
  logic                last_char;

  glyph_t       expected_glyphs[$];
  int           fail_count = 0;
  int           burst_left = 1;

  stall_mode_t  stall_mode = STALL_NONE;
  int           stall_span = 0;
  int           stall_phase = 0;

  // directed stimulus table, empty text means use the predictor
  logic [VALUE_W-1:0] row_value[$];
  logic [TAG_W-1:0]   row_tag[$];
  string              row_text[$];

  signed_int_to_decimal_ascii i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .stream_tag (stream_tag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .character  (character),
    .tag_out    (tag_out),
    .last_char  (last_char)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("signed_int_to_decimal_ascii test failed");
    $finish;
  end

  function automatic void push_glyph(logic [CHAR_W-1:0] ch, logic [TAG_W-1:0] tag, logic last);
    glyph_t g;
    g.ch   = ch;
    g.tag  = tag;
    g.last = last;
    expected_glyphs.push_back(g);
  endfunction

  // expected characters of one number, computed from its value
  function automatic void predict_text(logic [VALUE_W-1:0] raw, logic [TAG_W-1:0] tag);
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digs[NUM_DIGITS];
    int                 nd;
    neg = raw[VALUE_W-1];
    mag = neg ? (~raw + 1'b1) : raw;
    nd  = 0;
    do begin
      digs[nd] = 4'(mag % 10);
      mag      = mag / 10;
      nd++;
    end while (mag != 0 && nd < NUM_DIGITS);
    if (neg)
      push_glyph(CHAR_MINUS, tag, 1'b0);
    for (int i = nd - 1; i >= 0; i--)
      push_glyph(CHAR_ZERO + 8'(digs[i]), tag, i == 0);
  endfunction

  // expected characters typed in as text
  function automatic void expect_text(string s, logic [TAG_W-1:0] tag);
    for (int i = 0; i < s.len(); i++)
      push_glyph(s[i], tag, i == s.len() - 1);
  endfunction

  function automatic void add_row(logic [VALUE_W-1:0] v, logic [TAG_W-1:0] tag, string s);
    row_value.push_back(v);
    row_tag.push_back(tag);
    row_text.push_back(s);
  endfunction

  // random value spread over all text lengths and both signs
  function automatic logic [VALUE_W-1:0] pick_value();
    int                 sel;
    int                 k;
    int unsigned        lim;
    logic [VALUE_W-1:0] v;
    sel = $urandom_range(0, 9);
    k   = $urandom_range(0, 9);
    lim = 1;
    for (int i = 0; i < k; i++)
      lim = lim * 10;
    case (sel)
      0, 1, 2: v = $urandom;
      3, 4:    v = $urandom_range(0, lim - 1);
      5:       v = $urandom_range(0, 9);
      6:       v = lim - $urandom_range(0, 1);
      7: begin
        case ($urandom_range(0, 2))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          default: v = 32'h8000_0001;
        endcase
      end
      default: v = $urandom_range(0, 99999);
    endcase
    if (sel > 2 && sel != 7 && $urandom_range(0, 1) == 1)
      v = -v;
    return v;
  endfunction

  // one input transaction, then the sender's burst and gap pattern
  task automatic send_number(logic [VALUE_W-1:0] num, logic [TAG_W-1:0] tag, string text);
    int gap;
    int r;
    value      <= num;
    stream_tag <= tag;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (text.len() != 0)
      expect_text(text, tag);
    else
      predict_text(num, tag);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      r = $urandom_range(0, 7);
      case (r)
        0, 1:    gap = 0;
        6:       gap = $urandom_range(5, 20);
        7:       gap = $urandom_range(21, 50);
        default: gap = $urandom_range(1, 4);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sender holds off until every expected character has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
  endtask

  function automatic void check_glyph();
    glyph_t g;
    if (expected_glyphs.size() == 0) begin
      $error("unexpected character: character=%0d tag_out=%0d last_char=%0b",
             character, tag_out, last_char);
      fail_count++;
      return;
    end
    g = expected_glyphs.pop_front();
    if (character !== g.ch) begin
      $error("character: expected %0d, actual %0d", g.ch, character);
      fail_count++;
    end
    if (tag_out !== g.tag) begin
      $error("tag_out: expected %0d, actual %0d", g.tag, tag_out);
      fail_count++;
    end
    if (last_char !== g.last) begin
      $error("last_char: expected %0b, actual %0b", g.last, last_char);
      fail_count++;
    end
  endfunction

  // output monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      check_glyph();
    stall_phase++;
    if (stall_span <= 0) begin
      stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_HOLD));
      stall_span = (stall_mode == STALL_HOLD) ? $urandom_range(1, 20) : $urandom_range(10, 120);
    end
    stall_span--;
    case (stall_mode)
      STALL_NONE:        out_stall <= 1'b0;
      STALL_LIGHT:       out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:       out_stall <= ($urandom_range(0, 3) != 0);
      STALL_EVERY_THIRD: out_stall <= (stall_phase % 3 == 0);
      default:           out_stall <= 1'b1;
    endcase
  end

  // stimulus
  initial begin
    int drain;

    // extremes and digit count boundaries
    add_row(32'd0,          8'd0,   "0");
    add_row(32'h8000_0000,  8'd255, "-2147483648");
    add_row(32'h7fff_ffff,  8'haa,  "2147483647");
    add_row(-1,             8'h55,  "-1");
    add_row(32'd1,          8'd1,   "1");
    add_row(32'd9,          8'd2,   "9");
    add_row(32'd10,         8'd3,   "10");
    add_row(-9,             8'd4,   "-9");
    add_row(-10,            8'd5,   "-10");
    add_row(-2147483647,    8'd128, "-2147483647");
    add_row(32'd1000000000, 8'd127, "1000000000");
    add_row(32'd999999999,  8'd64,  "999999999");
    add_row(-1000000000,    8'd254, "-1000000000");
    // mixed values left to the predictor
    add_row(32'd123456789,  8'h0f,  "");
    add_row(-987654321,     8'hf0,  "");
    add_row(32'd42,         8'h33,  "");
    add_row(-7,             8'hcc,  "");
    add_row(32'd65535,      8'h01,  "");
    add_row(-65536,         8'h80,  "");
    add_row(32'h5555_5555,  8'h5a,  "");
    add_row(32'haaaa_aaaa,  8'ha5,  "");
    add_row(32'd100,        8'h77,  "");
    add_row(-100,           8'h88,  "");

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < row_value.size(); i++)
      send_number(row_value[i], row_tag[i], row_text[i]);

    wait_drained();

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (i == RANDOM_NUMBERS / 2)
        wait_drained();
      send_number(pick_value(), 8'($urandom_range(0, 255)), "");
    end

    // drain, then let the block settle
    in_valid <= 1'b0;
    drain = 0;
    while (expected_glyphs.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (60) @(posedge clk);

    if (expected_glyphs.size() != 0) begin
      $error("%0d expected characters never arrived", expected_glyphs.size());
      fail_count++;
    end

    if (fail_count == 0)
      $display("signed_int_to_decimal_ascii test passed");
    else
      $display("signed_int_to_decimal_ascii test failed");
    $finish;
  end

endmodule

>>> signed_int_to_decimal_ascii.f
rtl/sida_pkg.sv
rtl/sida_datapath.sv
rtl/sida_ctrl.sv
rtl/signed_int_to_decimal_ascii.sv
rtl/sida_checker.sv
bench/tb_top.sv
